// ===== hdl/lmx_pkg.sv =====
`default_nettype none

package lmx_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = QIDX_W + 1;
    localparam int NODE_W      = 4;
    localparam int CLOCK_W     = 15;
    localparam int PCOUNT_W    = 5;
    localparam int DONE_W      = 4;
    localparam int ENTRY_W     = NODE_W + CLOCK_W;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
    localparam logic [DONE_W-1:0]  DONE_MAX  = {DONE_W{1'b1}};
    localparam logic [PCOUNT_W-1:0] PARENT_AND_SELF = PCOUNT_W'(2);

    // action codes
    localparam logic [1:0] ACT_REQUEST = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_MESSAGE = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // received message kinds
    localparam logic [1:0] MSG_RELEASE = 2'd0;
    localparam logic [1:0] MSG_DONE    = 2'd1;
    localparam logic [1:0] MSG_REQUEST = 2'd2;
    localparam logic [1:0] MSG_REPLY   = 2'd3;

    // outgoing message kinds
    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_REPLY   = 2'd1;
    localparam logic [1:0] SEND_REQUEST = 2'd2;
    localparam logic [1:0] SEND_RELEASE = 2'd3;

    // register indexes
    localparam logic [0:0] CFG_SELF_ID       = 1'b0;
    localparam logic [0:0] CFG_PROCESS_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_UPDATE,
        ST_GRANT_CHECK,
        ST_GRANT_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic scan_clr;
        logic scan_step;
        logic drop_rd;
        logic drop_wr;
        logic update;
        logic grant_eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic [1:0] mtype;
        logic       count_zero;
        logic       scan_done;
        logic       grant_ready;
        logic       out_free;
    } status_t;

    function automatic logic [CLOCK_W-1:0] clock_bump(input logic [CLOCK_W-1:0] c);
        logic [CLOCK_W-1:0] r;
        if (c == CLOCK_MAX)
        begin
            r = CLOCK_MAX;
        end
        else
        begin
            r = c + CLOCK_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lamport_mutex_node.sv =====
`default_nettype none

// one node of lamport distributed mutual exclusion. each input word is a local
// request, a local release or a received message; each produces exactly one
// output word telling what to send (reply, multicast request, multicast release
// or nothing), the timestamp to send, whether this node now holds the critical
// section, whether a queue entry was dropped because the 16-entry queue was
// full, and the saturating count of done messages. one word is worked on at a
// time. an undefined action goes straight from decode to the finish state. a
// local release or a release message on a non-empty queue first searches for
// the minimum entry and drops it; a local release then updates and finishes,
// while a request or message updates and, when the grant may be due, searches
// the queue again for the grant. the minimum search reads one queue entry a
// cycle through the memory's registered read port and compares it with a
// single comparator. the result waits in the finish state while the output
// register is stalled, and the next word can be taken in the cycle after the
// result is loaded. a finished word sits in an output register, so a new word
// is taken while it waits. the queue needs no clearing pass after reset. the
// user must write self_id and process_count through the cfg port only while
// the node is idle; the block itself does not enforce it.

module lamport_mutex_node (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration writes
    input  wire logic                           cfg_wen,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [lmx_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     action,
    input  wire logic [1:0]                     msg_type,
    input  wire logic [lmx_pkg::CLOCK_W-1:0]    msg_time,
    input  wire logic [lmx_pkg::NODE_W-1:0]     peer_id,
    // output words
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [1:0]                     send_kind,
    output logic      [lmx_pkg::CLOCK_W-1:0]    send_time,
    output logic      [lmx_pkg::NODE_W-1:0]     send_dest,
    output logic                                granted,
    output logic                                queue_full,
    output logic      [lmx_pkg::DONE_W-1:0]     done_seen
);

    // commands from the sequencer and status back from the datapath
    lmx_pkg::cmd_t    cmd;
    lmx_pkg::status_t sts;

    // sequencer: decode, minimum search, drop, update, grant search, hand-off
    lmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: lamport clock, queue memory, counters and output register
    lmx_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .action     (action),
        .msg_type   (msg_type),
        .msg_time   (msg_time),
        .peer_id    (peer_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .send_kind  (send_kind),
        .send_time  (send_time),
        .send_dest  (send_dest),
        .granted    (granted),
        .queue_full (queue_full),
        .done_seen  (done_seen),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

`default_nettype wire

// ===== hdl/lmx_ram.sv =====
`default_nettype none

module lmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/lmx_ctrl.sv =====
`default_nettype none

module lmx_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire lmx_pkg::status_t sts,
    output lmx_pkg::cmd_t         cmd
);

    lmx_pkg::state_t state_reg;
    lmx_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            lmx_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = lmx_pkg::ST_DECODE;
                end
            end
            lmx_pkg::ST_DECODE:
            begin
                cmd.scan_clr = 1'b1;
                case (sts.act)
                    lmx_pkg::ACT_REQUEST:
                    begin
                        state_next = lmx_pkg::ST_UPDATE;
                    end
                    lmx_pkg::ACT_RELEASE:
                    begin
                        state_next = sts.count_zero ? lmx_pkg::ST_UPDATE : lmx_pkg::ST_SCAN;
                    end
                    lmx_pkg::ACT_MESSAGE:
                    begin
                        if (sts.mtype == lmx_pkg::MSG_RELEASE && !sts.count_zero)
                        begin
                            state_next = lmx_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = lmx_pkg::ST_UPDATE;
                        end
                    end
                    default:
                    begin
                        state_next = lmx_pkg::ST_FINISH;
                    end
                endcase
            end
            lmx_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = lmx_pkg::ST_DROP_RD;
                end
            end
            lmx_pkg::ST_DROP_RD:
            begin
                cmd.drop_rd = 1'b1;
                state_next  = lmx_pkg::ST_DROP_WR;
            end
            lmx_pkg::ST_DROP_WR:
            begin
                cmd.drop_wr = 1'b1;
                state_next  = lmx_pkg::ST_UPDATE;
            end
            lmx_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.act == lmx_pkg::ACT_RELEASE)
                begin
                    state_next = lmx_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = lmx_pkg::ST_GRANT_CHECK;
                end
            end
            lmx_pkg::ST_GRANT_CHECK:
            begin
                cmd.scan_clr = 1'b1;
                state_next   = sts.grant_ready ? lmx_pkg::ST_GRANT_SCAN : lmx_pkg::ST_FINISH;
            end
            lmx_pkg::ST_GRANT_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.grant_eval = 1'b1;
                    state_next     = lmx_pkg::ST_FINISH;
                end
            end
            lmx_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lmx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmx_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lmx_dp.sv =====
`default_nettype none

module lmx_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [lmx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]                     action,
    input  wire logic [1:0]                     msg_type,
    input  wire logic [lmx_pkg::CLOCK_W-1:0]    msg_time,
    input  wire logic [lmx_pkg::NODE_W-1:0]     peer_id,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [1:0]                     send_kind,
    output logic      [lmx_pkg::CLOCK_W-1:0]    send_time,
    output logic      [lmx_pkg::NODE_W-1:0]     send_dest,
    output logic                                granted,
    output logic                                queue_full,
    output logic      [lmx_pkg::DONE_W-1:0]     done_seen,
    input  wire lmx_pkg::cmd_t                  cmd,
    output lmx_pkg::status_t                    sts
);

    // configuration
    logic [lmx_pkg::NODE_W-1:0]   self_id_reg;
    logic [lmx_pkg::PCOUNT_W-1:0] process_count_reg;

    // protocol state
    logic [lmx_pkg::CLOCK_W-1:0]  lamport_clock_reg, lamport_clock_next;
    logic [lmx_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [lmx_pkg::PCOUNT_W-1:0] replies_reg, replies_next;
    logic                         waiting_reg, waiting_next;
    logic [lmx_pkg::DONE_W-1:0]   done_count_reg, done_count_next;

    // latched word
    logic [1:0]                   act_reg;
    logic [1:0]                   mtype_reg;
    logic [lmx_pkg::CLOCK_W-1:0]  mtime_reg;
    logic [lmx_pkg::NODE_W-1:0]   peer_reg;

    // minimum search
    logic [lmx_pkg::CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [lmx_pkg::QIDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                         best_vld_reg, best_vld_next;
    logic [lmx_pkg::QIDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [lmx_pkg::NODE_W-1:0]   best_node_reg, best_node_next;
    logic [lmx_pkg::CLOCK_W-1:0]  best_stamp_reg, best_stamp_next;

    // pending result
    logic [1:0]                   res_kind_reg, res_kind_next;
    logic [lmx_pkg::CLOCK_W-1:0]  res_time_reg, res_time_next;
    logic [lmx_pkg::NODE_W-1:0]   res_dest_reg, res_dest_next;
    logic                         res_full_reg, res_full_next;
    logic                         res_grant_reg, res_grant_next;

    // output register
    logic                         out_valid_reg;
    logic [1:0]                   out_kind_reg;
    logic [lmx_pkg::CLOCK_W-1:0]  out_time_reg;
    logic [lmx_pkg::NODE_W-1:0]   out_dest_reg;
    logic                         out_grant_reg;
    logic                         out_full_reg;
    logic [lmx_pkg::DONE_W-1:0]   out_done_reg;

    // queue memory
    logic                         ram_we;
    logic [lmx_pkg::QIDX_W-1:0]   ram_waddr;
    logic [lmx_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [lmx_pkg::QIDX_W-1:0]   ram_raddr;
    logic [lmx_pkg::ENTRY_W-1:0]  ram_rdata;

    logic [lmx_pkg::NODE_W-1:0]   ent_node;
    logic [lmx_pkg::CLOCK_W-1:0]  ent_stamp;
    logic                         ent_better;
    logic [lmx_pkg::CLOCK_W-1:0]  clk_base;
    logic [lmx_pkg::CLOCK_W-1:0]  clk_one;
    logic [lmx_pkg::CLOCK_W-1:0]  clk_two;
    logic [lmx_pkg::PCOUNT_W-1:0] replies_needed;
    logic                         do_push;
    logic [lmx_pkg::NODE_W-1:0]   push_node;
    logic [lmx_pkg::CLOCK_W-1:0]  push_stamp;
    logic                         queue_is_full;
    logic                         self_heads;

    lmx_ram #(
        .WIDTH (lmx_pkg::ENTRY_W),
        .DEPTH (lmx_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_node   = ram_rdata[lmx_pkg::ENTRY_W-1:lmx_pkg::CLOCK_W];
    assign ent_stamp  = ram_rdata[lmx_pkg::CLOCK_W-1:0];
    // earliest stamp wins, larger node id on a tie
    assign ent_better = !best_vld_reg || (ent_stamp < best_stamp_reg) ||
                        (ent_stamp == best_stamp_reg && ent_node > best_node_reg);

    assign clk_base = (act_reg == lmx_pkg::ACT_MESSAGE && mtime_reg > lamport_clock_reg) ?
                      mtime_reg : lamport_clock_reg;
    assign clk_one  = lmx_pkg::clock_bump(clk_base);
    assign clk_two  = lmx_pkg::clock_bump(clk_one);

    assign replies_needed = (process_count_reg >= lmx_pkg::PARENT_AND_SELF) ?
                            process_count_reg - lmx_pkg::PARENT_AND_SELF : '0;
    assign queue_is_full  = (count_reg == lmx_pkg::CNT_W'(lmx_pkg::QUEUE_DEPTH));
    assign self_heads     = (best_node_reg == self_id_reg);

    always_comb
    begin
        lamport_clock_next = lamport_clock_reg;
        count_next         = count_reg;
        replies_next       = replies_reg;
        waiting_next       = waiting_reg;
        done_count_next    = done_count_reg;
        scan_idx_next      = scan_idx_reg;
        rd_pend_next       = 1'b0;
        rd_idx_next        = rd_idx_reg;
        best_vld_next      = best_vld_reg;
        best_idx_next      = best_idx_reg;
        best_node_next     = best_node_reg;
        best_stamp_next    = best_stamp_reg;
        res_kind_next      = res_kind_reg;
        res_time_next      = res_time_reg;
        res_dest_next      = res_dest_reg;
        res_full_next      = res_full_reg;
        res_grant_next     = res_grant_reg;
        ram_we             = 1'b0;
        ram_waddr          = count_reg[lmx_pkg::QIDX_W-1:0];
        ram_wdata          = '0;
        ram_raddr          = scan_idx_reg[lmx_pkg::QIDX_W-1:0];
        do_push            = 1'b0;
        push_node          = self_id_reg;
        push_stamp         = clk_one;

        if (cmd.latch)
        begin
            res_kind_next  = lmx_pkg::SEND_NONE;
            res_time_next  = '0;
            res_dest_next  = '0;
            res_full_next  = 1'b0;
            res_grant_next = 1'b0;
        end

        if (cmd.scan_clr)
        begin
            scan_idx_next = '0;
            best_vld_next = 1'b0;
        end

        // one read issued and one entry compared per cycle
        if (cmd.scan_step)
        begin
            if (scan_idx_reg != count_reg)
            begin
                rd_pend_next  = 1'b1;
                rd_idx_next   = scan_idx_reg[lmx_pkg::QIDX_W-1:0];
                scan_idx_next = scan_idx_reg + lmx_pkg::CNT_W'(1);
            end
            if (rd_pend_reg && ent_better)
            begin
                best_vld_next   = 1'b1;
                best_idx_next   = rd_idx_reg;
                best_node_next  = ent_node;
                best_stamp_next = ent_stamp;
            end
        end

        // drop the minimum: move the last entry into its slot
        if (cmd.drop_rd)
        begin
            ram_raddr = lmx_pkg::QIDX_W'(count_reg - lmx_pkg::CNT_W'(1));
        end
        if (cmd.drop_wr)
        begin
            ram_we     = 1'b1;
            ram_waddr  = best_idx_reg;
            ram_wdata  = ram_rdata;
            count_next = count_reg - lmx_pkg::CNT_W'(1);
        end

        if (cmd.update)
        begin
            case (act_reg)
                lmx_pkg::ACT_REQUEST:
                begin
                    lamport_clock_next = clk_one;
                    do_push            = 1'b1;
                    res_kind_next      = lmx_pkg::SEND_REQUEST;
                    res_time_next      = clk_one;
                    waiting_next       = 1'b1;
                    replies_next       = replies_needed;
                end
                lmx_pkg::ACT_RELEASE:
                begin
                    lamport_clock_next = clk_one;
                    res_kind_next      = lmx_pkg::SEND_RELEASE;
                    res_time_next      = clk_one;
                    waiting_next       = 1'b0;
                end
                lmx_pkg::ACT_MESSAGE:
                begin
                    lamport_clock_next = clk_one;
                    case (mtype_reg)
                        lmx_pkg::MSG_DONE:
                        begin
                            if (done_count_reg != lmx_pkg::DONE_MAX)
                            begin
                                done_count_next = done_count_reg + lmx_pkg::DONE_W'(1);
                            end
                        end
                        lmx_pkg::MSG_REQUEST:
                        begin
                            do_push            = 1'b1;
                            push_node          = peer_reg;
                            push_stamp         = mtime_reg;
                            lamport_clock_next = clk_two;
                            res_kind_next      = lmx_pkg::SEND_REPLY;
                            res_time_next      = clk_two;
                            res_dest_next      = peer_reg;
                        end
                        lmx_pkg::MSG_REPLY:
                        begin
                            if (replies_reg != '0)
                            begin
                                replies_next = replies_reg - lmx_pkg::PCOUNT_W'(1);
                            end
                        end
                        default:
                        begin
                            // release: the minimum, if any, was already dropped
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            if (do_push)
            begin
                if (queue_is_full)
                begin
                    res_full_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[lmx_pkg::QIDX_W-1:0];
                    ram_wdata  = {push_node, push_stamp};
                    count_next = count_reg + lmx_pkg::CNT_W'(1);
                end
            end
        end

        if (cmd.grant_eval && self_heads)
        begin
            res_grant_next = 1'b1;
            waiting_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg       <= lmx_pkg::NODE_W'(1);
            process_count_reg <= lmx_pkg::PARENT_AND_SELF;
            lamport_clock_reg <= '0;
            count_reg         <= '0;
            replies_reg       <= '0;
            waiting_reg       <= 1'b0;
            done_count_reg    <= '0;
            rd_pend_reg       <= 1'b0;
            best_vld_reg      <= 1'b0;
            scan_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    lmx_pkg::CFG_SELF_ID:
                    begin
                        self_id_reg <= cfg_data[lmx_pkg::NODE_W-1:0];
                    end
                    lmx_pkg::CFG_PROCESS_COUNT:
                    begin
                        process_count_reg <= cfg_data[lmx_pkg::PCOUNT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            lamport_clock_reg <= lamport_clock_next;
            count_reg         <= count_next;
            replies_reg       <= replies_next;
            waiting_reg       <= waiting_next;
            done_count_reg    <= done_count_next;
            rd_pend_reg       <= rd_pend_next;
            best_vld_reg      <= best_vld_next;
            scan_idx_reg      <= scan_idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_node_reg   <= best_node_next;
        best_stamp_reg  <= best_stamp_next;
        res_kind_reg    <= res_kind_next;
        res_time_reg    <= res_time_next;
        res_dest_reg    <= res_dest_next;
        res_full_reg    <= res_full_next;
        res_grant_reg   <= res_grant_next;
        if (cmd.latch)
        begin
            act_reg   <= action;
            mtype_reg <= msg_type;
            mtime_reg <= msg_time;
            peer_reg  <= peer_id;
        end
        if (cmd.out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_time_reg  <= res_time_reg;
            out_dest_reg  <= res_dest_reg;
            out_grant_reg <= res_grant_reg;
            out_full_reg  <= res_full_reg;
            out_done_reg  <= done_count_reg;
        end
    end

    assign sts.act         = act_reg;
    assign sts.mtype       = mtype_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.scan_done   = (scan_idx_reg == count_reg) && !rd_pend_reg;
    assign sts.grant_ready = waiting_reg && (replies_reg == '0) && (count_reg != '0);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign send_kind  = out_kind_reg;
    assign send_time  = out_time_reg;
    assign send_dest  = out_dest_reg;
    assign granted    = out_grant_reg;
    assign queue_full = out_full_reg;
    assign done_seen  = out_done_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lmx_pkg::CNT_W'(lmx_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_wr |-> (count_reg != '0) && best_vld_reg)
        else $error("queue drop without a found minimum");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> lamport_clock_reg >= $past(lamport_clock_reg))
        else $error("lamport clock went backwards");

    a_grant_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grant_eval && self_heads) |=> !waiting_reg && res_grant_reg)
        else $error("grant left the wait flag set");

    a_grant_not_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_grant_reg) |-> (out_kind_reg != lmx_pkg::SEND_RELEASE))
        else $error("grant reported on a release");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lmx_pkg::*;

    // cycles with no handshake on either side before the run is declared hung
    localparam int HANG_LIMIT = 4000;

    // one output word of the node, as the port list shows it
    typedef struct {
        logic [1:0]         kind;
        logic [CLOCK_W-1:0] stamp;
        logic [NODE_W-1:0]  dest;
        logic               grant;
        logic               full;
        logic [DONE_W-1:0]  dones;
    } node_word_t;

    // mirror of one node: lamport clock, request queue, reply count, waiting
    // flag and done count, plus the words the block owes us in order
    class node_mirror;
        logic [NODE_W-1:0]   self_id = NODE_W'(1);
        logic [PCOUNT_W-1:0] pcount = PCOUNT_W'(2);
        logic [CLOCK_W-1:0]  lclock = '0;
        logic [NODE_W-1:0]   q_node [QUEUE_DEPTH];
        logic [CLOCK_W-1:0]  q_stamp [QUEUE_DEPTH];
        int                  q_cnt = 0;
        logic [PCOUNT_W-1:0] replies_owed = '0;
        bit                  waiting = 1'b0;
        logic [DONE_W-1:0]   dones = '0;
        node_word_t          owed_words[$];
        int                  errors = 0;

        function void write_reg(logic [0:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SELF_ID)
                self_id = data[NODE_W-1:0];
            else
                pcount = data[PCOUNT_W-1:0];
        endfunction

        // saturating clock step
        function logic [CLOCK_W-1:0] tick(logic [CLOCK_W-1:0] c);
            if (c == CLOCK_MAX)
                return CLOCK_MAX;
            return CLOCK_W'(c + 1'b1);
        endfunction

        // earliest stamp wins, larger node id on equal stamps
        function int head_index();
            int best;
            best = 0;
            for (int i = 1; i < q_cnt; i++)
            begin
                if (q_stamp[i] < q_stamp[best] ||
                    (q_stamp[i] == q_stamp[best] && q_node[i] > q_node[best]))
                    best = i;
            end
            return best;
        endfunction

        function bit enqueue(logic [NODE_W-1:0] node, logic [CLOCK_W-1:0] stamp);
            if (q_cnt >= QUEUE_DEPTH)
                return 1'b0;
            q_node[q_cnt] = node;
            q_stamp[q_cnt] = stamp;
            q_cnt++;
            return 1'b1;
        endfunction

        // the last entry moves into the hole
        function void drop_head();
            int m;
            if (q_cnt == 0)
                return;
            m = head_index();
            q_node[m] = q_node[q_cnt - 1];
            q_stamp[m] = q_stamp[q_cnt - 1];
            q_cnt--;
        endfunction

        function bit grant_check();
            if (waiting && replies_owed == 0 && q_cnt > 0 &&
                q_node[head_index()] == self_id)
            begin
                waiting = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // accepted input word: advance the node and queue the word it owes
        function void take_word(logic [1:0] act, logic [1:0] mt,
                                logic [CLOCK_W-1:0] mtime, logic [NODE_W-1:0] peer);
            node_word_t w;
            w.kind = SEND_NONE;
            w.stamp = '0;
            w.dest = '0;
            w.grant = 1'b0;
            w.full = 1'b0;
            case (act)
                ACT_REQUEST:
                begin
                    lclock = tick(lclock);
                    w.full = !enqueue(self_id, lclock);
                    w.kind = SEND_REQUEST;
                    w.stamp = lclock;
                    waiting = 1'b1;
                    replies_owed = (pcount >= PARENT_AND_SELF) ?
                                   PCOUNT_W'(pcount - PARENT_AND_SELF) : '0;
                    w.grant = grant_check();
                end
                ACT_RELEASE:
                begin
                    drop_head();
                    lclock = tick(lclock);
                    w.kind = SEND_RELEASE;
                    w.stamp = lclock;
                    waiting = 1'b0;
                end
                ACT_MESSAGE:
                begin
                    if (mtime > lclock)
                        lclock = mtime;
                    lclock = tick(lclock);
                    case (mt)
                        MSG_RELEASE: drop_head();
                        MSG_DONE:
                        begin
                            if (dones != DONE_MAX)
                                dones = DONE_W'(dones + 1'b1);
                        end
                        MSG_REQUEST:
                        begin
                            w.full = !enqueue(peer, mtime);
                            lclock = tick(lclock);
                            w.kind = SEND_REPLY;
                            w.stamp = lclock;
                            w.dest = peer;
                        end
                        default:
                        begin
                            if (replies_owed != 0)
                                replies_owed = PCOUNT_W'(replies_owed - 1'b1);
                        end
                    endcase
                    w.grant = grant_check();
                end
                default: ;
            endcase
            w.dones = dones;
            owed_words.push_back(w);
        endfunction

        function void cmp(string field, logic [CLOCK_W-1:0] want, logic [CLOCK_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_word(node_word_t got);
            node_word_t want;
            if (owed_words.size() == 0)
            begin
                errors++;
                $display("%0t: word with none expected, expected nothing actual kind %0d time %0d",
                         $time, got.kind, got.stamp);
                return;
            end
            want = owed_words.pop_front();
            cmp("send_kind", CLOCK_W'(want.kind), CLOCK_W'(got.kind));
            cmp("send_time", want.stamp, got.stamp);
            cmp("send_dest", CLOCK_W'(want.dest), CLOCK_W'(got.dest));
            cmp("granted", CLOCK_W'(want.grant), CLOCK_W'(got.grant));
            cmp("queue_full", CLOCK_W'(want.full), CLOCK_W'(got.full));
            cmp("done_seen", CLOCK_W'(want.dones), CLOCK_W'(got.dones));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    wire logic             in_stall;
    logic [1:0]            action = '0;
    logic [1:0]            msg_type = '0;
    logic [CLOCK_W-1:0]    msg_time = '0;
    logic [NODE_W-1:0]     peer_id = '0;
    wire logic             out_valid;
    logic                  out_stall = 1'b0;
    wire logic [1:0]       send_kind;
    wire logic [CLOCK_W-1:0] send_time;
    wire logic [NODE_W-1:0] send_dest;
    wire logic             granted;
    wire logic             queue_full;
    wire logic [DONE_W-1:0] done_seen;

    node_mirror sb = new;

    // stimulus shaping, changed per phase
    bit quiet = 1'b0;        // no idling on either side
    bit big_times = 1'b0;    // allow message times anywhere in range
    int fill_pct = 50;       // share of peer requests among queue-changing messages
    int words_left = 0;
    int hang_cycles = 0;

    lamport_mutex_node u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .msg_type   (msg_type),
        .msg_time   (msg_time),
        .peer_id    (peer_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .send_kind  (send_kind),
        .send_time  (send_time),
        .send_dest  (send_dest),
        .granted    (granted),
        .queue_full (queue_full),
        .done_seen  (done_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a longer one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(4, 40));
    endfunction

    // message time around the node's clock: near it, behind it or ahead of it
    function automatic logic [CLOCK_W-1:0] pick_time();
        int r;
        int base;
        int t;
        r = int'($urandom_range(0, 99));
        base = int'(sb.lclock);
        if (big_times && r < 15)
            t = int'($urandom_range(0, 32767));
        else if (r < 50)
            t = base + int'($urandom_range(0, 4));
        else if (r < 75)
            t = int'($urandom_range(0, base));
        else
            t = base + int'($urandom_range(5, 60));
        if (t > 32767)
            t = 32767;
        return CLOCK_W'(t);
    endfunction

    function automatic logic [NODE_W-1:0] any_peer();
        return NODE_W'($urandom_range(0, 15));
    endfunction

    // present one input word and hold it until the node takes it
    task automatic put(input logic [1:0] act, input logic [1:0] mt,
                       input logic [CLOCK_W-1:0] t, input logic [NODE_W-1:0] peer);
        if (!quiet && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        msg_type <= mt;
        msg_time <= t;
        peer_id <= peer;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_word(act, mt, t, peer);
        if (act != ACT_NONE)
            words_left--;
    endtask

    task automatic peer_msg(input logic [1:0] mt);
        put(ACT_MESSAGE, mt, pick_time(), any_peer());
    endtask

    // a peer joins the queue or one leaves it, biased by the phase
    task automatic churn();
        if ($urandom_range(0, 99) < fill_pct)
            peer_msg(MSG_REQUEST);
        else
            peer_msg(MSG_RELEASE);
    endtask

    // any word at all, undefined action included
    task automatic noise();
        put(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
            big_times ? CLOCK_W'($urandom_range(0, 32767)) : pick_time(), any_peer());
    endtask

    // one round of the protocol: request, collect replies among other traffic
    // until granted or out of steps, hold the section a little, then usually release
    task automatic session();
        int steps;
        int r;
        put(ACT_REQUEST, 2'($urandom_range(0, 3)), pick_time(), any_peer());
        steps = 0;
        while (sb.waiting && steps < 2 * int'(sb.pcount) + 8 && words_left > 0)
        begin
            r = int'($urandom_range(0, 99));
            if (sb.replies_owed != 0 && r < 60)
                peer_msg(MSG_REPLY);
            else if (r < 85)
                churn();
            else if (r < 93)
                peer_msg(MSG_DONE);
            else
                peer_msg(MSG_REPLY);
            steps++;
        end
        repeat ($urandom_range(0, 3))
        begin
            if (words_left > 0)
                churn();
        end
        // now and then the release is left out and the next request overlaps
        if ($urandom_range(0, 9) != 0)
            put(ACT_RELEASE, 2'($urandom_range(0, 3)), pick_time(), any_peer());
    endtask

    // wait until every owed word has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.owed_words.size() != 0)
            @(posedge clk);
    endtask

    // both registers on consecutive edges, node idle
    task automatic configure(input logic [NODE_W-1:0] id, input logic [PCOUNT_W-1:0] pc);
        cfg_wen <= 1'b1;
        cfg_index <= CFG_SELF_ID;
        cfg_data <= CFG_DATA_W'(id);
        @(posedge clk);
        sb.write_reg(CFG_SELF_ID, CFG_DATA_W'(id));
        cfg_index <= CFG_PROCESS_COUNT;
        cfg_data <= CFG_DATA_W'(pc);
        @(posedge clk);
        sb.write_reg(CFG_PROCESS_COUNT, CFG_DATA_W'(pc));
        cfg_wen <= 1'b0;
    endtask

    task automatic run_phase(input logic [NODE_W-1:0] id, input logic [PCOUNT_W-1:0] pc,
                             input int count, input int fill);
        settle();
        configure(id, pc);
        fill_pct = fill;
        words_left = count;
        while (words_left > 0)
        begin
            if ($urandom_range(0, 3) != 0)
                session();
            else
                noise();
        end
    endtask

    // result side: check every taken word, stall at random
    initial
    begin : result_side
        int stall_left;
        node_word_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.kind = send_kind;
                got.stamp = send_time;
                got.dest = send_dest;
                got.grant = granted;
                got.full = queue_full;
                got.dones = done_seen;
                sb.check_word(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 10)
            begin
                stall_left = gap_len() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // hang detection: any handshake, config write or reset restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen || !rst_n)
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("** lamport_mutex_node: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CLOCK_W-1:0] tie_t;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, node 1 of 2 so no replies are needed
        configure(NODE_W'(1), PCOUNT_W'(2));
        // undefined action with every message field at its top value
        put(ACT_NONE, MSG_REPLY, CLOCK_MAX, NODE_W'(15));
        // local release and release message on an empty queue
        put(ACT_RELEASE, MSG_RELEASE, '0, '0);
        put(ACT_MESSAGE, MSG_RELEASE, '0, '0);
        put(ACT_MESSAGE, MSG_DONE, '0, NODE_W'(15));
        // reply with nothing outstanding
        put(ACT_MESSAGE, MSG_REPLY, CLOCK_W'(3), NODE_W'(2));
        // request granted at once, then released
        put(ACT_REQUEST, MSG_RELEASE, '0, '0);
        put(ACT_RELEASE, MSG_RELEASE, '0, '0);
        // an earlier peer blocks the grant until its release arrives
        put(ACT_MESSAGE, MSG_REQUEST, '0, '0);
        put(ACT_REQUEST, MSG_RELEASE, '0, '0);
        put(ACT_MESSAGE, MSG_RELEASE, sb.lclock, NODE_W'(4));
        // repeated request while already holding an entry
        put(ACT_REQUEST, MSG_RELEASE, '0, '0);
        put(ACT_RELEASE, MSG_RELEASE, '0, '0);
        put(ACT_RELEASE, MSG_RELEASE, '0, '0);
        // equal stamps: the larger id leaves first
        tie_t = CLOCK_W'(sb.lclock + 2'd2);
        put(ACT_MESSAGE, MSG_REQUEST, tie_t, NODE_W'(2));
        put(ACT_MESSAGE, MSG_REQUEST, tie_t, NODE_W'(9));
        put(ACT_MESSAGE, MSG_RELEASE, tie_t, NODE_W'(2));
        put(ACT_REQUEST, MSG_RELEASE, '0, '0);
        put(ACT_MESSAGE, MSG_RELEASE, sb.lclock, NODE_W'(9));
        put(ACT_RELEASE, MSG_RELEASE, '0, '0);
        // fill the queue, then overflow it from a peer and from this node
        while (sb.q_cnt < QUEUE_DEPTH)
            put(ACT_MESSAGE, MSG_REQUEST, sb.lclock, any_peer());
        put(ACT_MESSAGE, MSG_REQUEST, sb.lclock, NODE_W'(7));
        put(ACT_REQUEST, MSG_RELEASE, '0, '0);

        // random phases over several settings
        run_phase(NODE_W'(15), PCOUNT_W'(16), 350, 55);
        quiet = 1'b1;
        run_phase(NODE_W'(7), PCOUNT_W'(4), 250, 40);
        quiet = 1'b0;
        // process counts below two need no replies at all
        run_phase(NODE_W'(3), PCOUNT_W'(1), 250, 65);
        run_phase(NODE_W'(12), PCOUNT_W'(0), 200, 45);
        run_phase(NODE_W'(9), PCOUNT_W'(6), 300, 50);

        // clock saturation last, since the clock never comes back down
        settle();
        configure(NODE_W'(15), PCOUNT_W'(3));
        big_times = 1'b1;
        put(ACT_MESSAGE, MSG_DONE, CLOCK_W'(CLOCK_MAX - 1'b1), NODE_W'(5));
        put(ACT_REQUEST, MSG_RELEASE, '0, '0);
        put(ACT_MESSAGE, MSG_REQUEST, CLOCK_MAX, NODE_W'(15));
        put(ACT_RELEASE, MSG_RELEASE, '0, '0);
        words_left = 200;
        while (words_left > 0)
        begin
            if ($urandom_range(0, 3) != 0)
                session();
            else
                noise();
        end

        // drain, then give a stray word time to show up
        settle();
        repeat (64) @(posedge clk);
        if (sb.errors == 0)
            $display("** lamport_mutex_node: PASSED **");
        else
            $display("** lamport_mutex_node: FAILED **");
        $finish;
    end

endmodule

// ===== lamport_mutex_node.f =====
hdl/lmx_pkg.sv
hdl/lmx_ram.sv
hdl/lmx_ctrl.sv
hdl/lmx_dp.sv
hdl/lamport_mutex_node.sv
tb/testbench.sv
